// ===== src/bitvector_alu_assert.svh =====
// Assertion macros for the bit-vector ALU
`ifndef BITVECTOR_ALU_ASSERT_SVH
`define BITVECTOR_ALU_ASSERT_SVH
`ifndef SYNTHESIS
`define BVA_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BVA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BVA_ASSERT_IMPL(label, clk, rst, ante, cons)
`define BVA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== src/bva_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package bva_pkg;
  localparam int Width = 32;
  localparam int CntW = $clog2(Width + 1);

  typedef enum logic [4:0] {
    CMD_ADD = 5'd0, CMD_SUB = 5'd1, CMD_NEG = 5'd2, CMD_NOT = 5'd3,
    CMD_AND = 5'd4, CMD_OR = 5'd5, CMD_XOR = 5'd6, CMD_NAND = 5'd7,
    CMD_NOR = 5'd8, CMD_XNOR = 5'd9, CMD_MUL = 5'd10, CMD_UDIV = 5'd11,
    CMD_UREM = 5'd12, CMD_SDIV = 5'd13, CMD_SREM = 5'd14, CMD_SMOD = 5'd15,
    CMD_SHL = 5'd16, CMD_LSHR = 5'd17, CMD_ASHR = 5'd18, CMD_EQ = 5'd19,
    CMD_ULT = 5'd20, CMD_ULE = 5'd21, CMD_UGT = 5'd22, CMD_UGE = 5'd23,
    CMD_SLT = 5'd24, CMD_SLE = 5'd25, CMD_SGT = 5'd26, CMD_SGE = 5'd27,
    CMD_ROTL = 5'd28, CMD_ROTR = 5'd29, CMD_RSV0 = 5'd30, CMD_RSV1 = 5'd31
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ITER, ST_FIX, ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture operands
    logic step;     // one multiply or divide bit
    logic fixup;    // sign fix-up and result select
    logic clear_cnt;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic iterative; // command needs the shared iterative unit
    logic last;      // final iteration
  } stat_t;
endpackage
`default_nettype wire

// ===== src/bva_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bva_datapath (
  input  wire logic                      clk,
  input  wire bva_pkg::ctrl_t            ctrl,
  output bva_pkg::stat_t                 stat,
  input  wire logic [4:0]                command,
  input  wire logic [31:0]               operand_a,
  input  wire logic [31:0]               operand_b,
  output logic [31:0]                    result_word,
  output logic                           condition,
  output logic                           carry_out
);
  import bva_pkg::*;

  localparam int W = Width;
  localparam logic [CntW-1:0] LastCnt = CntW'(W - 1);

  cmd_t          cmd;
  logic [W-1:0]  a, b;
  logic          sa, sb;
  logic [W-1:0]  acc;   // product or partial remainder
  logic [W-1:0]  qr;    // multiplier shift or quotient
  logic [W-1:0]  dvs;   // divisor magnitude or multiplicand
  logic [CntW-1:0] cnt;

  logic [W-1:0]  a_in, b_in, abs_a, abs_b;
  logic          iter_cmd;
  logic [W:0]    trial;
  logic [W-1:0]  r_comb;
  logic          c_comb, k_comb;
  logic [W:0]    sum;
  logic [W-1:0]  top;
  logic [W-1:0]  sh;
  logic          big;
  logic [CntW-1:0] rot;
  logic [2*W-1:0] rot2;
  logic [W-1:0]  u;

  assign a_in = W'(operand_a);
  assign b_in = W'(operand_b);

  always_comb begin
    iter_cmd = 1'b0;
    unique case (cmd) inside
      CMD_MUL, CMD_UDIV, CMD_UREM, CMD_SDIV, CMD_SREM, CMD_SMOD: iter_cmd = 1'b1;
      default: iter_cmd = 1'b0;
    endcase
  end
  assign stat.iterative = iter_cmd;
  assign stat.last = (cnt == LastCnt);

  assign abs_a = a[W-1] ? (~a + 1'b1) : a;
  assign abs_b = b[W-1] ? (~b + 1'b1) : b;
  assign trial = {acc, qr[W-1]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd <= cmd_t'(command);
      a   <= a_in;
      b   <= b_in;
    end else if (ctrl.clear_cnt) begin
      cnt <= '0;
      sa  <= a[W-1];
      sb  <= b[W-1];
      acc <= '0;
      if (cmd == CMD_MUL) begin
        qr  <= b;
        dvs <= a;
      end else if (cmd == CMD_UDIV || cmd == CMD_UREM) begin
        qr  <= a;
        dvs <= b;
      end else begin
        qr  <= abs_a;
        dvs <= abs_b;
      end
    end else if (ctrl.step) begin
      cnt <= cnt + 1'b1;
      if (cmd == CMD_MUL) begin
        // shift-add from the top bit of the multiplier
        acc <= {acc[W-2:0], 1'b0} + (qr[W-1] ? dvs : '0);
        qr  <= {qr[W-2:0], 1'b0};
      end else if (!trial[W]) begin
        acc <= trial[W-1:0];
        qr  <= {qr[W-2:0], 1'b1};
      end else begin
        acc <= {acc[W-2:0], qr[W-1]};
        qr  <= {qr[W-2:0], 1'b0};
      end
    end
  end

  // result select for every command, with sign fix-up
  always_comb begin
    r_comb = '0;
    c_comb = 1'b0;
    k_comb = 1'b0;
    sum    = {1'b0, a} + {1'b0, b};
    top    = {1'b1, {(W-1){1'b0}}};
    big    = (b >= W'(W));
    sh     = W'(b[CntW-1:0]);
    rot    = CntW'(b % W);
    rot2   = {a, a};
    u      = '0;
    case (cmd)
      CMD_ADD:  begin r_comb = sum[W-1:0]; c_comb = sum[W]; end
      CMD_SUB:  r_comb = a - b;
      CMD_NEG:  r_comb = ~a + 1'b1;
      CMD_NOT:  r_comb = ~a;
      CMD_AND:  r_comb = a & b;
      CMD_OR:   r_comb = a | b;
      CMD_XOR:  r_comb = a ^ b;
      CMD_NAND: r_comb = ~(a & b);
      CMD_NOR:  r_comb = ~(a | b);
      CMD_XNOR: r_comb = ~(a ^ b);
      CMD_MUL:  r_comb = acc;
      CMD_UDIV: r_comb = qr;
      CMD_UREM: r_comb = acc;
      CMD_SDIV: r_comb = (sa != sb) ? (~qr + 1'b1) : qr;
      CMD_SREM: r_comb = sa ? (~acc + 1'b1) : acc;
      CMD_SMOD: begin
        u = acc;
        if (u == '0 || (!sa && !sb)) r_comb = u;
        else if (sa && !sb)          r_comb = (~u + 1'b1) + b;
        else if (!sa && sb)          r_comb = u + b;
        else                         r_comb = ~u + 1'b1;
      end
      CMD_SHL:  r_comb = big ? '0 : (a << sh);
      CMD_LSHR: r_comb = big ? '0 : (a >> sh);
      CMD_ASHR: r_comb = big ? {W{a[W-1]}} : W'($signed(a) >>> sh);
      CMD_EQ:   k_comb = (a == b);
      CMD_ULT:  k_comb = (a < b);
      CMD_ULE:  k_comb = (a <= b);
      CMD_UGT:  k_comb = (a > b);
      CMD_UGE:  k_comb = (a >= b);
      CMD_SLT:  k_comb = ((a ^ top) < (b ^ top));
      CMD_SLE:  k_comb = ((a ^ top) <= (b ^ top));
      CMD_SGT:  k_comb = ((a ^ top) > (b ^ top));
      CMD_SGE:  k_comb = ((a ^ top) >= (b ^ top));
      CMD_ROTL: r_comb = rot2[2*W-1-rot -: W];
      CMD_ROTR: r_comb = rot2[rot +: W];
      default:  r_comb = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.fixup) begin
      result_word <= 32'(r_comb);
      condition   <= k_comb;
      carry_out   <= c_comb;
    end
  end
endmodule
`default_nettype wire

// ===== src/bva_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bva_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_fire,
  input  wire logic           out_ready,
  input  wire bva_pkg::stat_t stat,
  output bva_pkg::ctrl_t      ctrl,
  output logic                in_ready,
  output logic                out_valid
);
  import bva_pkg::*;

  state_t state, state_next;
  logic   setup, setup_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      setup <= 1'b0;
    end else begin
      state <= state_next;
      setup <= setup_next;
    end
  end

  always_comb begin
    state_next = state;
    setup_next = 1'b0;
    ctrl       = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          ctrl.load  = 1'b1;
          setup_next = 1'b1;
          state_next = ST_ITER;
        end
      end
      ST_ITER: begin
        if (setup) begin
          // load shift registers, then iterate or go straight to fix-up
          ctrl.clear_cnt = 1'b1;
          if (!stat.iterative) state_next = ST_FIX;
        end else begin
          ctrl.step = 1'b1;
          if (stat.last) state_next = ST_FIX;
        end
      end
      ST_FIX: begin
        ctrl.fixup = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== src/bitvector_alu.sv =====
// channel | handshake             | payload
// in      | in_valid / in_ready   | command, operand_a, operand_b
// out     | out_valid / out_ready | result_word, condition, carry_out
// One item at a time. Simple commands pass through setup, fix-up and output;
// mul, udiv, urem, sdiv, srem and smod also iterate in the shared bit-serial
// shift-add / restoring-divide unit. The next item is taken in the cycle after
// the result leaves. Synchronous reset clears the controller only.
// A stalled result holds in the output register.
`timescale 1ns / 1ps
`default_nettype none
`include "bitvector_alu_assert.svh"
module bitvector_alu (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [4:0]  command,
  input  wire logic [31:0] operand_a,
  input  wire logic [31:0] operand_b,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      result_word,
  output logic             condition,
  output logic             carry_out
);
  import bva_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  bva_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_valid && in_ready), .out_ready(out_ready),
    .stat(stat), .ctrl(ctrl), .in_ready(in_ready), .out_valid(out_valid)
  );

  bva_datapath u_dp (
    .clk(clk), .ctrl(ctrl), .stat(stat), .command(command),
    .operand_a(operand_a), .operand_b(operand_b), .result_word(result_word),
    .condition(condition), .carry_out(carry_out)
  );

  `BVA_ASSERT_IMPL(a_no_overlap, clk, rst, out_valid, !in_ready)
  `BVA_ASSERT_NEXT(a_accept_busy, clk, rst, in_valid && in_ready, !in_ready && !out_valid)
  `BVA_ASSERT_NEXT(a_drain_idle, clk, rst, out_valid && out_ready, in_ready)
  `BVA_ASSERT_IMPL(a_flags_excl, clk, rst, out_valid, !(condition && carry_out))
endmodule
`default_nettype wire

// ===== tb/bitvector_alu_tb.sv =====
`timescale 1ns / 1ps
module bitvector_alu_tb;
  import bva_pkg::*;

  localparam int WatchLimit = 20000;

  typedef struct packed {
    logic [31:0] word;
    logic        cond;
    logic        carry;
  } alu_res_t;

  typedef struct {
    cmd_t        cmd;
    logic [31:0] a;
    logic [31:0] b;
    logic        typed;
    alu_res_t    res;
  } vec_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [4:0]  command;
  logic [31:0] operand_a;
  logic [31:0] operand_b;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] result_word;
  logic        condition;
  logic        carry_out;

  alu_res_t pending_res[$];
  int       n_errors;
  int       idle_pct;
  int       stall_pct;
  int       quiet_cycles;

  bitvector_alu u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .operand_a(operand_a), .operand_b(operand_b),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_word(result_word), .condition(condition), .carry_out(carry_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] neg32(logic [31:0] x);
    return 32'd0 - x;
  endfunction

  function automatic alu_res_t alu_predict(cmd_t cmd, logic [31:0] a, logic [31:0] b);
    alu_res_t    r;
    logic [32:0] sum;
    logic        sa;
    logic        sb;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [31:0] q;
    logic [31:0] rm;
    int          k;
    r = '0;
    sa = a[31];
    sb = b[31];
    ma = sa ? neg32(a) : a;
    mb = sb ? neg32(b) : b;
    q = (mb == 0) ? '1 : ma / mb;
    rm = (mb == 0) ? ma : ma % mb;
    case (cmd)
      CMD_ADD: begin
        sum = {1'b0, a} + {1'b0, b};
        r.word = sum[31:0];
        r.carry = sum[32];
      end
      CMD_SUB:  r.word = a - b;
      CMD_NEG:  r.word = neg32(a);
      CMD_NOT:  r.word = ~a;
      CMD_AND:  r.word = a & b;
      CMD_OR:   r.word = a | b;
      CMD_XOR:  r.word = a ^ b;
      CMD_NAND: r.word = ~(a & b);
      CMD_NOR:  r.word = ~(a | b);
      CMD_XNOR: r.word = ~(a ^ b);
      CMD_MUL:  r.word = a * b;
      CMD_UDIV: r.word = (b == 0) ? '1 : a / b;
      CMD_UREM: r.word = (b == 0) ? a : a % b;
      CMD_SDIV: r.word = (sa != sb) ? neg32(q) : q;
      CMD_SREM: r.word = sa ? neg32(rm) : rm;
      CMD_SMOD: begin
        if (rm == 0 || (!sa && !sb)) r.word = rm;
        else if (sa && !sb) r.word = neg32(rm) + b;
        else if (!sa && sb) r.word = rm + b;
        else r.word = neg32(rm);
      end
      CMD_SHL:  r.word = (b >= 32) ? '0 : a << b[4:0];
      CMD_LSHR: r.word = (b >= 32) ? '0 : a >> b[4:0];
      CMD_ASHR: r.word = (b >= 32) ? {32{sa}} : $unsigned($signed(a) >>> b[4:0]);
      CMD_EQ:   r.cond = (a == b);
      CMD_ULT:  r.cond = (a < b);
      CMD_ULE:  r.cond = (a <= b);
      CMD_UGT:  r.cond = (a > b);
      CMD_UGE:  r.cond = (a >= b);
      CMD_SLT:  r.cond = ($signed(a) < $signed(b));
      CMD_SLE:  r.cond = ($signed(a) <= $signed(b));
      CMD_SGT:  r.cond = ($signed(a) > $signed(b));
      CMD_SGE:  r.cond = ($signed(a) >= $signed(b));
      CMD_ROTL: begin
        k = b % 32;
        r.word = (k == 0) ? a : ((a << k) | (a >> (32 - k)));
      end
      CMD_ROTR: begin
        k = b % 32;
        r.word = (k == 0) ? a : ((a >> k) | (a << (32 - k)));
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  // idle at the current rate, then hold the item until accepted
  task automatic send_item(cmd_t cmd, logic [31:0] a, logic [31:0] b, alu_res_t res);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    operand_a <= a;
    operand_b <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_res.push_back(res);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_res.size() != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(7))
      0: return 32'h0;
      1: return 32'hffff_ffff;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      4: return $urandom_range(40);
      5: return neg32($urandom_range(40));
      default: return $urandom;
    endcase
  endfunction

  // receiver side: random stall and checking
  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    alu_res_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_res.size() == 0) begin
        $display("unexpected result %h at %0t", result_word, $realtime);
        n_errors++;
      end else begin
        want = pending_res.pop_front();
        if (result_word !== want.word) report_mismatch("result_word", result_word, want.word);
        if (condition !== want.cond) report_mismatch("condition", condition, want.cond);
        if (carry_out !== want.carry) report_mismatch("carry_out", carry_out, want.carry);
      end
    end
  end

  // watchdog on accepted and returned items
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    vec_t     dir_tab[$];
    vec_t     v;
    alu_res_t r;
    cmd_t     cmd;
    logic [31:0] a;
    logic [31:0] b;
    int       phase;
    int       i;
    rst = 1'b1;
    in_valid = 1'b0;
    out_ready = 1'b0;
    command = '0;
    operand_a = '0;
    operand_b = '0;
    n_errors = 0;
    idle_pct = 0;
    stall_pct = 0;
    quiet_cycles = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    dir_tab = '{
      '{CMD_ADD, 32'hffff_ffff, 32'h1, 1'b1, '{32'h0, 1'b0, 1'b1}},
      '{CMD_ADD, 32'hffff_ffff, 32'hffff_ffff, 1'b1, '{32'hffff_fffe, 1'b0, 1'b1}},
      '{CMD_SUB, 32'h0, 32'h1, 1'b1, '{32'hffff_ffff, 1'b0, 1'b0}},
      '{CMD_NEG, 32'h8000_0000, 32'h0, 1'b1, '{32'h8000_0000, 1'b0, 1'b0}},
      '{CMD_NOT, 32'h0, 32'hffff_ffff, 1'b1, '{32'hffff_ffff, 1'b0, 1'b0}},
      '{CMD_AND, 32'hf0f0_f0f0, 32'hff00_ff00, 1'b0, '0},
      '{CMD_OR, 32'hf0f0_f0f0, 32'h0f0f_0f0f, 1'b0, '0},
      '{CMD_XOR, 32'hffff_ffff, 32'haaaa_5555, 1'b0, '0},
      '{CMD_NAND, 32'hffff_ffff, 32'hffff_ffff, 1'b1, '{32'h0, 1'b0, 1'b0}},
      '{CMD_NOR, 32'h0, 32'h0, 1'b1, '{32'hffff_ffff, 1'b0, 1'b0}},
      '{CMD_XNOR, 32'h1234_5678, 32'h8765_4321, 1'b0, '0},
      '{CMD_MUL, 32'hffff_ffff, 32'hffff_ffff, 1'b1, '{32'h1, 1'b0, 1'b0}},
      '{CMD_UDIV, 32'h1234_5678, 32'h0, 1'b1, '{32'hffff_ffff, 1'b0, 1'b0}},
      '{CMD_UREM, 32'h1234_5678, 32'h0, 1'b1, '{32'h1234_5678, 1'b0, 1'b0}},
      '{CMD_SDIV, 32'hffff_fff9, 32'h0, 1'b1, '{32'h1, 1'b0, 1'b0}},
      '{CMD_SDIV, 32'h8000_0000, 32'hffff_ffff, 1'b1, '{32'h8000_0000, 1'b0, 1'b0}},
      '{CMD_SDIV, 32'h7, 32'hffff_fffe, 1'b0, '0},
      '{CMD_SREM, 32'hffff_fff9, 32'h2, 1'b0, '0},
      '{CMD_SMOD, 32'hffff_fff9, 32'h2, 1'b0, '0},
      '{CMD_SMOD, 32'h7, 32'hffff_fffe, 1'b0, '0},
      '{CMD_ASHR, 32'h8000_0000, 32'd40, 1'b1, '{32'hffff_ffff, 1'b0, 1'b0}},
      '{CMD_SHL, 32'hffff_ffff, 32'd32, 1'b1, '{32'h0, 1'b0, 1'b0}},
      '{CMD_LSHR, 32'hffff_ffff, 32'd31, 1'b1, '{32'h1, 1'b0, 1'b0}},
      '{CMD_ROTL, 32'h8000_0001, 32'd33, 1'b1, '{32'h3, 1'b0, 1'b0}},
      '{CMD_ROTR, 32'h1, 32'hffff_ffff, 1'b0, '0},
      '{CMD_SLT, 32'h8000_0000, 32'h7fff_ffff, 1'b1, '{32'h0, 1'b1, 1'b0}},
      '{CMD_RSV1, 32'hffff_ffff, 32'hffff_ffff, 1'b1, '{32'h0, 1'b0, 1'b0}}
    };
    foreach (dir_tab[j]) begin
      v = dir_tab[j];
      r = v.typed ? v.res : alu_predict(v.cmd, v.a, v.b);
      send_item(v.cmd, v.a, v.b, r);
    end
    // comparisons on the extremes
    for (i = CMD_EQ; i <= CMD_SGE; i++) begin
      cmd = cmd_t'(i);
      send_item(cmd, 32'hffff_ffff, 32'h0, alu_predict(cmd, 32'hffff_ffff, 32'h0));
    end

    // pause the sender until everything is back
    wait_drained();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 75; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 75; end
        default: begin idle_pct = 22; stall_pct = 22; end
      endcase
      for (i = 0; i < 110; i++) begin
        cmd = cmd_t'($urandom_range(31));
        a = rand_operand();
        b = rand_operand();
        if (cmd inside {CMD_SHL, CMD_LSHR, CMD_ASHR, CMD_ROTL, CMD_ROTR}
            && $urandom_range(1)) b = $urandom_range(70);
        send_item(cmd, a, b, alu_predict(cmd, a, b));
      end
    end
    stall_pct = 0;
    wait_drained();
    repeat (40) @(posedge clk);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
